### design/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants and payload types of the sliding anagram matcher.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int SAM_ALPHABET_SIZE = 256;
  localparam int SAM_MAX_PATTERN   = 64;

  localparam int FUNC_W = 2;
  localparam int SYM_W  = 8;
  localparam int POS_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [POS_W-1:0]  pos_t;

endpackage

### design/sam_if.sv
// ----------------------------------------------------------------------------
// sam_if
// Request and result channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface sam_req_if;
  import sam_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  sym_t  symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface sam_res_if;
  import sam_pkg::*;

  logic valid;
  logic ready;
  logic window_full;
  logic match;
  pos_t start_index;

  modport source (output valid, output window_full, output match, output start_index,
                  input ready);
  modport sink   (input valid, input window_full, input match, input start_index,
                  output ready);
endinterface

### design/sliding_anagram_matcher_unit.sv
// ----------------------------------------------------------------------------
// sliding_anagram_matcher_unit
// Reports, per text symbol, whether the last pattern-length window of text is
// an anagram of the loaded pattern.
// ----------------------------------------------------------------------------
// A clear request completes in ST_IDLE, a pattern request goes on to ST_PAT
// and a text request to ST_LEAVE and ST_ENTER (straight to ST_ENTER while
// the pattern is empty or the window is still filling); the block takes one
// request at a time. This follows from the single port pair of the difference
// table RAM: a text symbol needs one read-modify-write for the symbol leaving
// the window and one for the symbol entering it, each with a registered read.
// The leaving symbol is prefetched from the history RAM while the block
// waits. A finished result sits in an output register, and the next request
// is taken while it waits; only the final step of a text request holds until
// that register is free. Table entries carry one valid bit each, so a clear
// (and reset) empties the table at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sliding_anagram_matcher_unit #(
  parameter int ALPHABET_SIZE = sam_pkg::SAM_ALPHABET_SIZE,
  parameter int MAX_PATTERN   = sam_pkg::SAM_MAX_PATTERN
) (
  input  logic         clk,
  input  logic         rst_n,
  sam_req_if.sink      in_req,
  sam_res_if.source    out_res
);
  import sam_pkg::*;

  // Table index, ring pointer, pattern length, leave sum, table entry and mismatch count widths, and fold table size.
  localparam int IDX_W  = $clog2(ALPHABET_SIZE);
  localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PL_W   = $clog2(MAX_PATTERN + 1);
  localparam int LV_W   = PL_W + 1;
  localparam int DIFF_W = PL_W + 1;
  localparam int MC_W   = $clog2(ALPHABET_SIZE + 1);
  localparam int LUT_N  = 1 << SYM_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,   // wait for a request
    ST_PAT   = 4'b0010,   // write back a pattern symbol's entry
    ST_LEAVE = 4'b0100,   // write back the leaving symbol's entry
    ST_ENTER = 4'b1000    // write back the entering symbol's entry, emit result
  } state_t;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // Adjust the count of nonzero entries after one entry changes.
  function automatic logic [MC_W-1:0] mism_adj(input logic [MC_W-1:0] cnt,
                                               input diff_t old_v,
                                               input diff_t new_v);
    logic [MC_W-1:0] res;
    res = cnt;
    if (new_v == '0) begin
      if (cnt != '0) begin
        res = cnt - 1'b1;
      end
    end else if (old_v == '0) begin
      res = cnt + 1'b1;
    end
    return res;
  endfunction

  // Fold a byte into the alphabet: constant table worked out at elaboration.
  logic [IDX_W-1:0] fold_lut [LUT_N];
  for (genvar g = 0; g < LUT_N; g++) begin : g_fold
    assign fold_lut[g] = IDX_W'(g % ALPHABET_SIZE);
  end

  // Registers
  state_t                   state_r,      state_nxt;
  logic [PL_W-1:0]          pat_len_r,    pat_len_nxt;
  pos_t                     text_pos_r,   text_pos_nxt;
  logic [RING_W-1:0]        ring_ptr_r,   ring_ptr_nxt;
  logic [MC_W-1:0]          mism_r,       mism_nxt;
  logic [ALPHABET_SIZE-1:0] valid_r,      valid_nxt;
  logic [IDX_W-1:0]         leave_sym_r,  leave_sym_nxt;
  logic [IDX_W-1:0]         enter_sym_r,  enter_sym_nxt;
  logic                     fwd_r,        fwd_nxt;
  diff_t                    fwd_val_r,    fwd_val_nxt;
  logic                     empty_r,      empty_nxt;
  logic                     out_valid_r,  out_valid_nxt;
  logic                     out_full_r,   out_full_nxt;
  logic                     out_match_r,  out_match_nxt;
  pos_t                     out_start_r,  out_start_nxt;

  // RAM ports
  logic              tab_we;
  logic [IDX_W-1:0]  tab_waddr;
  logic [DIFF_W-1:0] tab_wdata;
  logic [IDX_W-1:0]  tab_raddr;
  logic [DIFF_W-1:0] tab_rdata;
  logic              hist_we;
  logic [RING_W-1:0] hist_raddr;
  logic [IDX_W-1:0]  hist_rdata;

  // Request decode and datapath helpers
  logic              accept;
  logic [IDX_W-1:0]  in_sym;
  logic              window_was_full;
  pos_t              tp_inc;
  logic [LV_W-1:0]   leave_sum;
  logic [IDX_W-1:0]  rd_sym;
  diff_t             tab_old;
  diff_t             tab_cur;
  diff_t             tab_inc;
  diff_t             tab_dec;
  logic [MC_W-1:0]   mism_enter;
  logic              full_new;
  logic              out_free;

  assign accept = in_req.valid & in_req.ready;
  assign in_sym = fold_lut[in_req.symbol];

  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.window_full = out_full_r;
  assign out_res.match       = out_match_r;
  assign out_res.start_index = out_start_r;

  assign window_was_full = (text_pos_r >= POS_W'(pat_len_r));
  assign tp_inc = (text_pos_r == '1) ? text_pos_r : text_pos_r + 1'b1;
  assign full_new = (tp_inc >= POS_W'(pat_len_r));
  assign out_free = !out_valid_r || out_res.ready;

  // Oldest window slot: ring pointer minus pattern length, modulo ring size.
  assign leave_sum = LV_W'(ring_ptr_r) + LV_W'(MAX_PATTERN) - LV_W'(pat_len_r);
  assign hist_raddr = (leave_sum >= LV_W'(MAX_PATTERN))
                    ? RING_W'(leave_sum - LV_W'(MAX_PATTERN))
                    : RING_W'(leave_sum);

  // Entry being modified; an entry never written since clear reads as zero.
  // Forward the leaving write when both symbols hit the same entry.
  assign rd_sym  = (state_r == ST_LEAVE) ? leave_sym_r : enter_sym_r;
  assign tab_old = valid_r[rd_sym] ? $signed(tab_rdata) : diff_t'(0);
  assign tab_cur = (state_r == ST_ENTER && fwd_r) ? fwd_val_r : tab_old;
  assign tab_inc = tab_cur + diff_t'(1);
  assign tab_dec = tab_cur - diff_t'(1);
  assign mism_enter = mism_adj(mism_r, tab_cur, tab_dec);

  always_comb begin
    state_nxt     = state_r;
    pat_len_nxt   = pat_len_r;
    text_pos_nxt  = text_pos_r;
    ring_ptr_nxt  = ring_ptr_r;
    mism_nxt      = mism_r;
    valid_nxt     = valid_r;
    leave_sym_nxt = leave_sym_r;
    enter_sym_nxt = enter_sym_r;
    fwd_nxt       = fwd_r;
    fwd_val_nxt   = fwd_val_r;
    empty_nxt     = empty_r;
    out_full_nxt  = out_full_r;
    out_match_nxt = out_match_r;
    out_start_nxt = out_start_r;
    tab_we        = 1'b0;
    tab_waddr     = rd_sym;
    tab_wdata     = tab_inc;
    tab_raddr     = enter_sym_r;
    hist_we       = 1'b0;

    // Drop the result once the sink takes it.
    out_valid_nxt = out_valid_r && !out_res.ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.func)
            FUNC_CLEAR: begin
              pat_len_nxt  = '0;
              text_pos_nxt = '0;
              ring_ptr_nxt = '0;
              mism_nxt     = '0;
              valid_nxt    = '0;
            end
            FUNC_PATTERN: begin
              // Only before any text and while there is room.
              if (text_pos_r == '0 && pat_len_r < PL_W'(MAX_PATTERN)) begin
                tab_raddr     = in_sym;
                enter_sym_nxt = in_sym;
                pat_len_nxt   = pat_len_r + 1'b1;
                state_nxt     = ST_PAT;
              end
            end
            FUNC_TEXT: begin
              enter_sym_nxt = in_sym;
              fwd_nxt       = 1'b0;
              if (pat_len_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_ENTER;
              end else begin
                empty_nxt    = 1'b0;
                hist_we      = 1'b1;
                ring_ptr_nxt = (ring_ptr_r == RING_W'(MAX_PATTERN - 1))
                             ? '0 : ring_ptr_r + 1'b1;
                if (window_was_full) begin
                  // Prefetched oldest symbol leaves first.
                  tab_raddr     = hist_rdata;
                  leave_sym_nxt = hist_rdata;
                  state_nxt     = ST_LEAVE;
                end else begin
                  tab_raddr = in_sym;
                  state_nxt = ST_ENTER;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PAT: begin
        tab_we             = 1'b1;
        tab_wdata          = tab_inc;
        valid_nxt[rd_sym]  = 1'b1;
        mism_nxt           = mism_adj(mism_r, tab_cur, tab_inc);
        state_nxt          = ST_IDLE;
      end

      ST_LEAVE: begin
        tab_we             = 1'b1;
        tab_wdata          = tab_inc;
        valid_nxt[rd_sym]  = 1'b1;
        mism_nxt           = mism_adj(mism_r, tab_cur, tab_inc);
        tab_raddr          = enter_sym_r;
        fwd_nxt            = (leave_sym_r == enter_sym_r);
        fwd_val_nxt        = tab_inc;
        state_nxt          = ST_ENTER;
      end

      ST_ENTER: begin
        // Hold the read address so a stalled cycle sees the same entry.
        tab_raddr = enter_sym_r;
        if (out_free) begin
          text_pos_nxt  = tp_inc;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (empty_r) begin
            out_full_nxt  = 1'b0;
            out_match_nxt = 1'b0;
            out_start_nxt = '0;
          end else begin
            tab_we            = 1'b1;
            tab_wdata         = tab_dec;
            valid_nxt[rd_sym] = 1'b1;
            mism_nxt          = mism_enter;
            out_full_nxt      = full_new;
            out_match_nxt     = full_new && (mism_enter == '0);
            out_start_nxt     = full_new ? tp_inc - POS_W'(pat_len_r) : '0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pat_len_r   <= '0;
      text_pos_r  <= '0;
      ring_ptr_r  <= '0;
      mism_r      <= '0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_len_r   <= pat_len_nxt;
      text_pos_r  <= text_pos_nxt;
      ring_ptr_r  <= ring_ptr_nxt;
      mism_r      <= mism_nxt;
      valid_r     <= valid_nxt;
      fwd_r       <= fwd_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    leave_sym_r <= leave_sym_nxt;
    enter_sym_r <= enter_sym_nxt;
    fwd_val_r   <= fwd_val_nxt;
    out_full_r  <= out_full_nxt;
    out_match_r <= out_match_nxt;
    out_start_r <= out_start_nxt;
  end

  // Difference table: pattern count minus window count per symbol.
  sam_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (ALPHABET_SIZE),
    .AW    (IDX_W)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Window history ring; read continuously at the oldest slot.
  sam_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PATTERN),
    .AW    (RING_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ring_ptr_r),
    .wdata (in_sym),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

endmodule

### design/sam_ram.sv
// ----------------------------------------------------------------------------
// sam_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sam_checker.sv
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks of the sliding anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
module sam_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input sam_pkg::func_t       in_func,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_window_full,
  input logic                 out_match,
  input sam_pkg::pos_t        out_start_index
);
  import sam_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_full)
      && $stable(out_match) && $stable(out_start_index))
    else $error("result changed while stalled");

  // Only text requests produce results.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func != FUNC_TEXT) && !out_valid |=> !out_valid)
    else $error("result after a non-text request");

  // A text request leaves the block busy: ready drops in the cycle after it is taken.
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_TEXT) |=> !in_ready)
    else $error("request taken while a text request is in flight");

  // A match only comes with a full window.
  a_match_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match |-> out_window_full)
    else $error("match without a full window");

  // Without a full window the start index is zero.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_full |-> out_start_index == '0)
    else $error("nonzero start index without a full window");

endmodule

bind sliding_anagram_matcher_unit sam_checker u_sam_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_func         (in_req.func),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_window_full (out_res.window_full),
  .out_match       (out_res.match),
  .out_start_index (out_res.start_index)
);
